@@ src/matrix_multiply_4x4_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the matrix multiply core
// Concurrent checks, clocked on the rising edge and held off during reset.
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_4X4_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that the consequent holds in the same cycle as the antecedent
`define MM4_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MM4_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/mm4_pkg.sv @@
// ---------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants of the fixed-point matrix multiply core.
// ---------------------------------------------------------------------------
package mm4_pkg;

    // Element word width and output index width
    localparam int WORD_W    = 32;
    localparam int IDX_OUT_W = 2;

    // Saturation limits of a signed word
    localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

    // Controller states
    typedef enum logic [2:0] {
        S_LOAD,
        S_ISSUE,
        S_DRAIN,
        S_RESULT,
        S_SEND
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic left_we;
        logic right_we;
        logic issue;
        logic acc_clear;
        logic finish;
    } t_dp_cmd;

endpackage

@@ src/mm4_datapath.sv @@
// ---------------------------------------------------------------------------
// mm4_datapath
// Element stores, shared multiply-accumulate unit and the result register.
// ---------------------------------------------------------------------------
module mm4_datapath #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mm4_pkg::t_dp_cmd                    i_cmd,
    input  logic [$clog2(2*DIM*DIM)-1:0]        i_left_wr_addr,
    input  logic [$clog2(DIM*DIM)-1:0]          i_right_wr_addr,
    input  logic [$clog2(2*DIM*DIM)-1:0]        i_left_rd_addr,
    input  logic [$clog2(DIM*DIM)-1:0]          i_right_rd_addr,
    input  logic signed [mm4_pkg::WORD_W-1:0]   i_element_value,
    output logic                                o_busy,
    output logic signed [mm4_pkg::WORD_W-1:0]   o_product_value,
    output logic                                o_overflow
);

    localparam int NELEM = DIM * DIM;
    localparam int IDX_W = $clog2(DIM);
    localparam int PROD_W = 2 * mm4_pkg::WORD_W;
    localparam int ACC_W = PROD_W + IDX_W + 1;
    localparam int WORD_W = mm4_pkg::WORD_W;

    // Left store holds two banks so a chained product never overwrites its operands
    logic [WORD_W-1:0] r_left_mem [2*NELEM];
    logic [WORD_W-1:0] r_right_mem [NELEM];

    logic signed [WORD_W-1:0] r_rd_left;
    logic signed [WORD_W-1:0] r_rd_right;
    logic                     r_rd_valid;
    logic signed [PROD_W-1:0] r_mul;
    logic                     r_mul_valid;
    logic signed [ACC_W-1:0]  r_acc;
    logic [WORD_W-1:0]        r_product;
    logic                     r_overflow;

    logic signed [ACC_W-1:0]  scaled;
    logic                     fits;
    logic [WORD_W-1:0]        sat_value;
    logic                     sat_flag;

    // Write the stores: loaded words, or the saturated product into the left store
    always_ff @(posedge i_clk) begin
        if (i_cmd.left_we) begin
            r_left_mem[i_left_wr_addr] <= i_cmd.finish ? sat_value : i_element_value;
        end
        if (i_cmd.right_we) begin
            r_right_mem[i_right_wr_addr] <= i_element_value;
        end
    end

    // Read one operand pair per issue
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_left  <= r_left_mem[i_left_rd_addr];
            r_rd_right <= r_right_mem[i_right_rd_addr];
        end
    end

    // Multiply, then accumulate at full width
    always_ff @(posedge i_clk) begin
        r_mul <= r_rd_left * r_rd_right;
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_mul_valid) begin
            r_acc <= r_acc + ACC_W'(r_mul);
        end
    end

    // Track words in flight through the read and multiply stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_mul_valid <= 1'b0;
        end else begin
            r_rd_valid  <= i_cmd.issue;
            r_mul_valid <= r_rd_valid;
        end
    end

    // Truncate toward minus infinity and saturate to one word
    always_comb begin
        scaled    = r_acc >>> FRAC_BITS;
        fits      = (&scaled[ACC_W-1:WORD_W-1]) || !(|scaled[ACC_W-1:WORD_W-1]);
        sat_flag  = !fits;
        if (fits) begin
            sat_value = scaled[WORD_W-1:0];
        end else if (scaled[ACC_W-1]) begin
            sat_value = mm4_pkg::SAT_MIN;
        end else begin
            sat_value = mm4_pkg::SAT_MAX;
        end
    end

    // Hold the finished word for the output channel
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_product  <= sat_value;
            r_overflow <= sat_flag;
        end
    end

    assign o_busy          = r_rd_valid || r_mul_valid;
    assign o_product_value = r_product;
    assign o_overflow      = r_overflow;

endmodule

@@ src/mm4_controller.sv @@
// ---------------------------------------------------------------------------
// mm4_controller
// Load sequencing, dot-product issue, output handshake and chain bank swap.
// ---------------------------------------------------------------------------
`include "matrix_multiply_4x4_core_macros.svh"

module mm4_controller #(
    parameter int DIM = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    output logic                                o_valid,
    input  logic                                i_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_chain_mode,
    input  logic                                i_busy,
    output mm4_pkg::t_dp_cmd                    o_cmd,
    output logic [$clog2(2*DIM*DIM)-1:0]        o_left_wr_addr,
    output logic [$clog2(DIM*DIM)-1:0]          o_right_wr_addr,
    output logic [$clog2(2*DIM*DIM)-1:0]        o_left_rd_addr,
    output logic [$clog2(DIM*DIM)-1:0]          o_right_rd_addr,
    output logic [mm4_pkg::IDX_OUT_W-1:0]       o_row_index,
    output logic [mm4_pkg::IDX_OUT_W-1:0]       o_col_index,
    output logic                                o_last
);

    localparam int NELEM   = DIM * DIM;
    localparam int IDX_W   = $clog2(DIM);
    localparam int ELEM_W  = $clog2(NELEM);
    localparam int LADDR_W = $clog2(2 * NELEM);
    localparam logic [LADDR_W-1:0] POS_RIGHT = LADDR_W'(NELEM);
    localparam logic [LADDR_W-1:0] POS_LAST  = LADDR_W'(2 * NELEM - 1);
    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(DIM - 1);
    localparam logic [ELEM_W-1:0]  DIM_E     = ELEM_W'(DIM);

    mm4_pkg::t_state r_state, n_state;
    logic [LADDR_W-1:0] r_load_pos, n_load_pos;
    logic               r_bank, n_bank;
    logic [IDX_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0]   r_col, n_col;
    logic [IDX_W-1:0]   r_k, n_k;
    logic               r_chain, n_chain;
    logic               r_out_valid, n_out_valid;

    logic [ELEM_W-1:0]  load_elem;
    logic [ELEM_W-1:0]  left_elem;
    logic [ELEM_W-1:0]  prod_elem;
    logic [LADDR_W-1:0] bank_base;
    logic [LADDR_W-1:0] other_base;
    logic               last_word;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm4_pkg::S_LOAD;
            r_load_pos  <= '0;
            r_bank      <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            r_chain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_pos  <= n_load_pos;
            r_bank      <= n_bank;
            r_row       <= n_row;
            r_col       <= n_col;
            r_k         <= n_k;
            r_chain     <= n_chain;
            r_out_valid <= n_out_valid;
        end
    end

    assign last_word = (r_row == IDX_LAST) && (r_col == IDX_LAST);

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_load_pos  = r_load_pos;
        n_bank      = r_bank;
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        n_chain     = i_cfg_valid ? i_cfg_chain_mode : r_chain;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            mm4_pkg::S_LOAD: begin
                if (i_valid) begin
                    if (r_load_pos < POS_RIGHT) begin
                        o_cmd.left_we = 1'b1;
                    end else begin
                        o_cmd.right_we = 1'b1;
                    end
                    if (r_load_pos == POS_LAST) begin
                        n_state = mm4_pkg::S_ISSUE;
                        n_row   = '0;
                        n_col   = '0;
                        n_k     = '0;
                    end else begin
                        n_load_pos = r_load_pos + 1'b1;
                    end
                end
            end
            mm4_pkg::S_ISSUE: begin
                o_cmd.issue     = 1'b1;
                o_cmd.acc_clear = (r_k == '0);
                if (r_k == IDX_LAST) begin
                    n_k     = '0;
                    n_state = mm4_pkg::S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            mm4_pkg::S_DRAIN: begin
                // wait for the last term to reach the accumulator
                if (!i_busy) begin
                    n_state = mm4_pkg::S_RESULT;
                end
            end
            mm4_pkg::S_RESULT: begin
                o_cmd.finish  = 1'b1;
                o_cmd.left_we = 1'b1;
                n_out_valid   = 1'b1;
                n_state       = mm4_pkg::S_SEND;
            end
            mm4_pkg::S_SEND: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    if (last_word) begin
                        // swap banks when the product becomes the next left matrix
                        if (r_chain) begin
                            n_bank     = !r_bank;
                            n_load_pos = POS_RIGHT;
                        end else begin
                            n_load_pos = '0;
                        end
                        n_state = mm4_pkg::S_LOAD;
                    end else begin
                        if (r_col == IDX_LAST) begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                        n_state = mm4_pkg::S_ISSUE;
                    end
                end
            end
            default: begin
                n_state = mm4_pkg::S_LOAD;
            end
        endcase
    end

    // Store addresses
    always_comb begin
        bank_base  = r_bank ? LADDR_W'(NELEM) : '0;
        other_base = r_bank ? '0 : LADDR_W'(NELEM);
        if (r_load_pos < POS_RIGHT) begin
            load_elem = ELEM_W'(r_load_pos);
        end else begin
            load_elem = ELEM_W'(r_load_pos - POS_RIGHT);
        end
        left_elem = ELEM_W'(r_row) * DIM_E + ELEM_W'(r_k);
        prod_elem = ELEM_W'(r_row) * DIM_E + ELEM_W'(r_col);
        if (r_state == mm4_pkg::S_RESULT) begin
            o_left_wr_addr = other_base + LADDR_W'(prod_elem);
        end else begin
            o_left_wr_addr = bank_base + LADDR_W'(load_elem);
        end
        o_right_wr_addr = load_elem;
        o_left_rd_addr  = bank_base + LADDR_W'(left_elem);
        o_right_rd_addr = ELEM_W'(r_k) * DIM_E + ELEM_W'(r_col);
    end

    assign o_stall     = (r_state != mm4_pkg::S_LOAD);
    assign o_valid     = r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign o_row_index = mm4_pkg::IDX_OUT_W'(r_row);
    assign o_col_index = mm4_pkg::IDX_OUT_W'(r_col);
    assign o_last      = last_word;

    `MM4_ASSERT_NEXT(a_load_done_issue, i_clk, i_rst_n, i_valid && !o_stall && (r_load_pos == POS_LAST), r_state == mm4_pkg::S_ISSUE, "final load word did not start the product")
    `MM4_ASSERT_NEXT(a_issue_then_drain, i_clk, i_rst_n, (r_state == mm4_pkg::S_ISSUE) && (r_k == IDX_LAST), (r_state == mm4_pkg::S_DRAIN) && i_busy, "last term issue did not enter drain")
    `MM4_ASSERT_NOW(a_result_drained, i_clk, i_rst_n, r_state == mm4_pkg::S_RESULT, !i_busy, "result taken with terms in flight")
    `MM4_ASSERT_NEXT(a_restart_pos, i_clk, i_rst_n, o_valid && !i_stall && o_last, (r_state == mm4_pkg::S_LOAD) && (r_load_pos == ($past(r_chain) ? POS_RIGHT : '0)), "wrong load restart after product")

endmodule

@@ src/matrix_multiply_4x4_core.sv @@
// Each product word issues its DIM terms on one shared multiply-accumulate unit, then passes
// through the drain, result and send states; the next word starts only once this one is taken.
// Load words are taken one per cycle while the core is in its load state (o_stall low).
// Reset (synchronous, active low) restarts loading at the left matrix and clears chain mode.
// ---------------------------------------------------------------------------
// matrix_multiply_4x4_core
// Streaming DIM x DIM signed fixed-point matrix multiply with optional chaining
// of the product into the next left matrix.
// ---------------------------------------------------------------------------
module matrix_multiply_4x4_core #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [mm4_pkg::WORD_W-1:0]   i_element_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mm4_pkg::WORD_W-1:0]   o_product_value,
    output logic [mm4_pkg::IDX_OUT_W-1:0]       o_row_index,
    output logic [mm4_pkg::IDX_OUT_W-1:0]       o_col_index,
    output logic                                o_overflow,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_chain_mode
);

    localparam int NELEM   = DIM * DIM;
    localparam int ELEM_W  = $clog2(NELEM);
    localparam int LADDR_W = $clog2(2 * NELEM);

    mm4_pkg::t_dp_cmd    cmd;
    logic                busy;
    logic [LADDR_W-1:0]  left_wr_addr;
    logic [ELEM_W-1:0]   right_wr_addr;
    logic [LADDR_W-1:0]  left_rd_addr;
    logic [ELEM_W-1:0]   right_rd_addr;

    // Sequence loads, term issue and word delivery
    mm4_controller #(
        .DIM (DIM)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_chain_mode (i_cfg_chain_mode),
        .i_busy           (busy),
        .o_cmd            (cmd),
        .o_left_wr_addr   (left_wr_addr),
        .o_right_wr_addr  (right_wr_addr),
        .o_left_rd_addr   (left_rd_addr),
        .o_right_rd_addr  (right_rd_addr),
        .o_row_index      (o_row_index),
        .o_col_index      (o_col_index),
        .o_last           (o_last)
    );

    // Stores, multiply-accumulate and saturation
    mm4_datapath #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_left_wr_addr  (left_wr_addr),
        .i_right_wr_addr (right_wr_addr),
        .i_left_rd_addr  (left_rd_addr),
        .i_right_rd_addr (right_rd_addr),
        .i_element_value (i_element_value),
        .o_busy          (busy),
        .o_product_value (o_product_value),
        .o_overflow      (o_overflow)
    );

endmodule

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench for matrix_multiply_4x4_core
// Streams left and right matrix words into the core, predicts every product
// word with its own fixed-point model and checks each one in order. Covers
// saturation in both directions, exact boundary values, chain mode set
// mid-load and cleared while a left matrix is held, random idling on both
// channels and a long receiver hold-off that backs the core up.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic signed [mm4_pkg::WORD_W-1:0] value;
    logic [mm4_pkg::IDX_OUT_W-1:0]     row;
    logic [mm4_pkg::IDX_OUT_W-1:0]     col;
    logic                              ovf;
    logic                              last;
} t_product_word;

// Fixed-point product predictor and in-order store of expected product words
class product_scoreboard;
    localparam int N     = 4;
    localparam int NSQ   = N * N;
    localparam int FRAC  = 16;
    localparam int PRINT_CAP = 30;
    localparam logic signed [71:0] FIT_HI = 72'sd2147483647;
    localparam logic signed [71:0] FIT_LO = -72'sd2147483648;

    logic signed [31:0] left_m[NSQ];
    logic signed [31:0] right_m[NSQ];
    int unsigned        load_pos;
    bit                 chain_on;
    t_product_word      expected_q[$];
    int unsigned        mismatches;
    int unsigned        words_checked;
    int unsigned        products_done;
    int unsigned        saturated_words;

    function new();
        load_pos = 0;
        chain_on = 1'b0;
        mismatches = 0;
        words_checked = 0;
        products_done = 0;
        saturated_words = 0;
    endfunction

    function void set_chain(bit mode);
        chain_on = mode;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // Words still needed before the next product is emitted
    function int unsigned elements_to_product();
        if (load_pos >= 2 * NSQ)
            return 2 * NSQ;
        return 2 * NSQ - load_pos;
    endfunction

    // Dot product of a left row and a right column, scaled and saturated
    function t_product_word dot_word(int r, int c);
        logic signed [71:0] acc;
        logic signed [71:0] scaled;
        logic signed [63:0] a;
        logic signed [63:0] b;
        t_product_word      w;
        acc = '0;
        for (int k = 0; k < N; k++) begin
            a = left_m[r * N + k];
            b = right_m[k * N + c];
            acc = acc + a * b;
        end
        scaled = acc >>> FRAC;
        w.row = r[1:0];
        w.col = c[1:0];
        w.last = (r == N - 1) && (c == N - 1);
        if (scaled > FIT_HI) begin
            w.value = mm4_pkg::SAT_MAX;
            w.ovf = 1'b1;
        end else if (scaled < FIT_LO) begin
            w.value = mm4_pkg::SAT_MIN;
            w.ovf = 1'b1;
        end else begin
            w.value = scaled[31:0];
            w.ovf = 1'b0;
        end
        return w;
    endfunction

    // Load one accepted word; on the last right word queue the whole product
    function void note_element(logic signed [31:0] v);
        logic signed [31:0] prod[NSQ];
        t_product_word      w;
        if (load_pos >= 2 * NSQ)
            load_pos = 0;
        if (load_pos < NSQ) begin
            left_m[load_pos] = v;
            load_pos++;
            return;
        end
        right_m[load_pos - NSQ] = v;
        load_pos++;
        if (load_pos < 2 * NSQ)
            return;
        for (int r = 0; r < N; r++) begin
            for (int c = 0; c < N; c++) begin
                w = dot_word(r, c);
                prod[r * N + c] = w.value;
                if (w.ovf)
                    saturated_words++;
                expected_q.push_back(w);
            end
        end
        // Keep the product as the next left matrix in chain mode
        if (chain_on) begin
            left_m = prod;
            load_pos = NSQ;
        end else begin
            load_pos = 0;
        end
    endfunction

    task report(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Compare one accepted product word with the oldest expectation
    task check_product(t_product_word got);
        t_product_word want;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected word row %0d col %0d value %h",
                             got.row, got.col, got.value));
            return;
        end
        want = expected_q.pop_front();
        words_checked++;
        if (got.value !== want.value)
            report($sformatf("word %0d value got %h want %h",
                             words_checked, got.value, want.value));
        if (got.row !== want.row)
            report($sformatf("word %0d row got %0d want %0d",
                             words_checked, got.row, want.row));
        if (got.col !== want.col)
            report($sformatf("word %0d col got %0d want %0d",
                             words_checked, got.col, want.col));
        if (got.ovf !== want.ovf)
            report($sformatf("word %0d overflow got %b want %b",
                             words_checked, got.ovf, want.ovf));
        if (got.last !== want.last)
            report($sformatf("word %0d last got %b want %b",
                             words_checked, got.last, want.last));
        if (want.last)
            products_done++;
    endtask
endclass

module testbench;
    localparam int RAND_ITEMS   = 400;
    localparam int SETTLE       = 36;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 38;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic signed [mm4_pkg::WORD_W-1:0]  i_element_value;
    logic                               o_valid;
    logic                               i_stall;
    logic signed [mm4_pkg::WORD_W-1:0]  o_product_value;
    logic [mm4_pkg::IDX_OUT_W-1:0]      o_row_index;
    logic [mm4_pkg::IDX_OUT_W-1:0]      o_col_index;
    logic                               o_overflow;
    logic                               o_last;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic                               i_cfg_chain_mode;

    product_scoreboard sb;
    t_product_word     seen_word;
    bit                gaps_on;
    bit                hold_req;
    int unsigned       items_sent;
    int unsigned       chain_writes;
    int unsigned       chain_sets;
    int unsigned       cycle_count;

    matrix_multiply_4x4_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_element_value  (i_element_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_product_value  (o_product_value),
        .o_row_index      (o_row_index),
        .o_col_index      (o_col_index),
        .o_overflow       (o_overflow),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_chain_mode (i_cfg_chain_mode)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run as a failure if it reaches the cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d product words outstanding",
                 cycle_count, sb.pending());
        $display("testbench: FAIL");
        $finish;
    end

    // Receiver: random stall, or one long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Check every product word taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_word.value = o_product_value;
            seen_word.row   = o_row_index;
            seen_word.col   = o_col_index;
            seen_word.ovf   = o_overflow;
            seen_word.last  = o_last;
            sb.check_product(seen_word);
        end
    end

    // Offer one word, idling first at random, and hold it until taken
    task automatic send_element(input logic [31:0] v);
        @(negedge i_clk);
        while (gaps_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_element_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_element(v);
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Wait until every expected word has arrived, then let the core settle
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_chain(input logic mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_chain_mode <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_chain(mode);
        chain_writes++;
        if (mode)
            chain_sets++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random word: mostly small Q16.16 values, some full range and corners
    function automatic logic [31:0] pick_element();
        int          roll;
        int          offset;
        logic [31:0] word;
        logic [31:0] corners[7];
        corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
                    32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000};
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            offset = $urandom_range(0, 524288);
            word = 32'(offset - 262144);
        end else if (roll < 80) begin
            word = $urandom();
        end else if (roll < 90) begin
            word = corners[$urandom_range(0, 6)];
        end else begin
            offset = $urandom_range(0, 33554432);
            word = 32'(offset - 16777216);
        end
        return word;
    endfunction

    // Stimulus
    initial begin
        logic [31:0] dir_left[16];
        logic [31:0] dir_right[16];
        logic [31:0] dir_next[16];
        int unsigned rand_sent;
        int unsigned remaining;
        int unsigned count;
        int          phase;

        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_element_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_chain_mode = 1'b0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        items_sent = 0;
        chain_writes = 0;
        chain_sets = 0;
        rand_sent = 0;
        phase = 0;

        // Rows: all max, all min, exact one in column zero, mixed small
        dir_left = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 32'h0000_8000};
        // Columns: all max, all min, small signed, mixed fractions
        dir_right = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0001_8000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_7FFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0002};
        // Near identity with corners, applied to the held product
        dir_next = '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
                     32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                     32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000,
                     32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000};

        // Hold reset, then release it on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Start the left matrix with chain mode off, then set it mid-load
        for (int i = 0; i < 10; i++) send_element(dir_left[i]);
        release_input();
        wait_drained();
        write_chain(1'b1);
        for (int i = 10; i < 16; i++) send_element(dir_left[i]);
        for (int i = 0; i < 16; i++) send_element(dir_right[i]);
        release_input();
        wait_drained();

        // Clear chain mode while the product is held as the left matrix
        write_chain(1'b0);
        for (int i = 0; i < 16; i++) send_element(dir_next[i]);
        release_input();
        wait_drained();

        // Random phases: mostly full products, some partial loads
        while (rand_sent < RAND_ITEMS) begin
            phase++;
            gaps_on = (phase < 6) || (phase > 9);
            remaining = sb.elements_to_product();
            count = remaining;
            if (phase == 3) begin
                // Back the core up: receiver holds off while words keep coming
                hold_req = 1'b1;
                count = remaining + 32;
            end else if ($urandom_range(0, 4) == 0) begin
                count = $urandom_range(1, remaining);
            end
            repeat (count) begin
                send_element(pick_element());
                rand_sent++;
            end
            release_input();
            wait_drained();
            if ($urandom_range(0, 1) == 1)
                write_chain(1'($urandom_range(0, 1)));
        end

        gaps_on = 1'b1;
        release_input();
        wait_drained();

        $display("covered %0d input words, %0d product words in %0d products, %0d saturated",
                 items_sent, sb.words_checked, sb.products_done, sb.saturated_words);
        $display("chain mode written %0d times (%0d set), one %0d-cycle receiver hold-off",
                 chain_writes, chain_sets, HOLD_CYCLES);
        if (sb.mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
